// ----- rtl/core/tnat_pkg.sv -----
// tnat_pkg: shared types, constants and helpers for the TCP NAT mapping table.
// Depends on nothing; every module of the block imports it.
package tnat_pkg;

  localparam int ENTRIES = 256;
  localparam int IW      = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    OP_OUT  = 2'd0,
    OP_IN   = 2'd1,
    OP_TICK = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_NEW   = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_BAD   = 3'd4,
    ST_SWEEP = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_EXT_IP  = 2'd0,
    REG_BASE    = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    FIN_OPEN = 2'd0,
    FIN_SEEN = 2'd1,
    FIN_RST  = 2'd2
  } fin_code_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic        fin_flag;
    logic        rst_flag;
    logic        ack_flag;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_ip;
    logic [15:0] new_port;
    logic [8:0]  removed_count;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] inside_ip;
    logic [15:0] inside_port;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [31:0] inside_seq_end;
    logic [31:0] inside_ack;
    logic [1:0]  inside_fin_state;
    logic [31:0] outside_seq_end;
    logic [31:0] outside_ack;
    logic [1:0]  outside_fin_state;
    logic [31:0] last_touch;
  } entry_t;

  // Work the head does on the entry passing it this cycle.
  typedef enum logic [1:0] {
    HM_OUT   = 2'd0,
    HM_IN    = 2'd1,
    HM_TICK  = 2'd2,
    HM_CLAIM = 2'd3
  } hmode_t;

  typedef struct packed {
    hmode_t      mode;
    logic        searching;   // no hit yet in this pass
    logic        claim_here;  // entry at head is the one being claimed
    logic [15:0] ext_port;    // external port of the entry at head
    logic [31:0] tick_now;
    logic [15:0] timeout;
  } head_ctrl_t;

  typedef struct packed {
    logic took;     // hit found and updated
    logic is_free;
    logic kill;
  } head_ev_t;

  function automatic logic [1:0] next_fin(logic [1:0] old, logic fin, logic rst);
    logic [1:0] r;
    r = old;
    if (rst)      r = FIN_RST;
    else if (fin) r = FIN_SEEN;
    return r;
  endfunction

endpackage

// ----- rtl/core/tnat_cell.sv -----
// tnat_cell: one storage cell of the rotating entry chain.
// Depends on tnat_pkg for entry_t.
module tnat_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  tnat_pkg::entry_t d,
  output tnat_pkg::entry_t q
);
  import tnat_pkg::*;

  logic   held_valid;
  entry_t held;

  // Valid bit is control state, cleared by reset; the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (shift) begin
      held_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  always_comb begin
    q       = held;
    q.valid = held_valid;
  end

endmodule

// ----- rtl/core/tnat_head.sv -----
// tnat_head: match, update, claim and age logic applied to the entry at the
// head of the chain. Depends on tnat_pkg.
module tnat_head (
  input  tnat_pkg::entry_t     e_in,
  input  tnat_pkg::in_t        req,
  input  tnat_pkg::head_ctrl_t ctrl,
  output tnat_pkg::entry_t     e_out,
  output tnat_pkg::head_ev_t   ev
);
  import tnat_pkg::*;

  logic        out_match;
  logic        in_match;
  logic        finished;
  logic        aged;
  logic [31:0] idle;

  assign out_match = e_in.valid && e_in.inside_ip == req.src_ip &&
                     e_in.inside_port == req.src_port &&
                     e_in.server_ip == req.dst_ip && e_in.server_port == req.dst_port;
  assign in_match  = e_in.valid && e_in.server_ip == req.src_ip &&
                     e_in.server_port == req.src_port && ctrl.ext_port == req.dst_port;

  assign idle     = ctrl.tick_now - e_in.last_touch;
  assign aged     = idle > {16'd0, ctrl.timeout};
  assign finished = e_in.inside_fin_state == FIN_SEEN &&
                    e_in.outside_fin_state == FIN_SEEN &&
                    e_in.inside_ack >= e_in.outside_seq_end &&
                    e_in.outside_ack >= e_in.inside_seq_end;

  always_comb begin
    e_out = e_in;
    ev    = '0;
    ev.is_free = !e_in.valid;
    case (ctrl.mode)
      HM_OUT: begin
        if (ctrl.searching && out_match) begin
          ev.took              = 1'b1;
          e_out.inside_seq_end = req.seq_num;
          if (req.ack_flag) e_out.inside_ack = req.ack_num;
          e_out.inside_fin_state = next_fin(e_in.inside_fin_state, req.fin_flag,
                                            req.rst_flag);
          e_out.last_touch     = ctrl.tick_now;
        end
      end
      HM_IN: begin
        if (ctrl.searching && in_match) begin
          ev.took               = 1'b1;
          e_out.outside_seq_end = req.seq_num;
          if (req.ack_flag) e_out.outside_ack = req.ack_num;
          e_out.outside_fin_state = next_fin(e_in.outside_fin_state, req.fin_flag,
                                             req.rst_flag);
          e_out.last_touch      = ctrl.tick_now;
        end
      end
      HM_TICK: begin
        if (e_in.valid && (e_in.inside_fin_state == FIN_RST ||
                           e_in.outside_fin_state == FIN_RST || finished || aged)) begin
          ev.kill     = 1'b1;
          e_out.valid = 1'b0;
        end
      end
      HM_CLAIM: begin
        if (ctrl.claim_here) begin
          e_out.valid             = 1'b1;
          e_out.inside_ip         = req.src_ip;
          e_out.inside_port       = req.src_port;
          e_out.server_ip         = req.dst_ip;
          e_out.server_port       = req.dst_port;
          e_out.inside_seq_end    = req.seq_num;
          e_out.inside_ack        = req.ack_flag ? req.ack_num : 32'd0;
          e_out.inside_fin_state  = next_fin(FIN_OPEN, req.fin_flag, req.rst_flag);
          e_out.outside_seq_end   = 32'd0;
          e_out.outside_ack       = 32'd0;
          e_out.outside_fin_state = FIN_OPEN;
          e_out.last_touch        = ctrl.tick_now;
        end
      end
      default: begin
        e_out = e_in;
      end
    endcase
  end

endmodule

// ----- rtl/core/tcp_nat_mapping_table.sv -----
// tcp_nat_mapping_table: TCP port-translation table built as a rotating chain
// of entry cells with one shared head unit. Depends on tnat_pkg, tnat_cell,
// tnat_head.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data) carries one transaction:
//    an outbound packet, an inbound packet or a one-second tick.
//  - Output channel (out_valid / out_stall / out_data) returns exactly one
//    result transaction per input transaction, in order.
//  - Config port (cfg_we / cfg_idx / cfg_data) writes the public address,
//    port_base and timeout_ticks; write only while the block is idle.
//  - All ENTRIES entries sit in a ring of cells that shifts one place per
//    cycle during a scan or claim pass; the head unit sees the entries in
//    index order in a revolution, so lowest index wins naturally.
//  - Sequence: packets and ticks make one revolution (S_SCAN), then S_FIN
//    loads the result register; an outbound miss that claims a new entry
//    makes a second revolution (S_CLAIM) before S_FIN. Invalid operations
//    and inbound packets to a foreign address go from accept straight to
//    S_FIN. One transaction is in work at a time; the next one is taken the
//    cycle after the result is registered.
//  - in_stall is high while a transaction is in work; the finished result
//    waits in the output register while out_stall is high.
//  - Reset clears every valid bit at once and resets the config registers and
//    the tick counter; no clearing pass is needed.
module tcp_nat_mapping_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tnat_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tnat_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_idx,
  input  logic [31:0]    cfg_data
);
  import tnat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_CLAIM = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t      state;
  in_t         req;
  out_t        res;
  logic [IW-1:0] pos;        // index of the entry at the head
  logic        found;
  logic        free_found;
  logic [IW-1:0] free_idx;
  logic [31:0] tick_now;
  logic [31:0] pub_ip;
  logic [15:0] port_base;
  logic [15:0] timeout_ticks;

  entry_t      chain [ENTRIES];
  entry_t      head_out;
  head_ctrl_t  hctrl;
  head_ev_t    hev;
  logic        shift;
  logic        in_acc;
  logic [15:0] pos_port;
  logic        free_now;
  logic [IW-1:0] free_sel;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign shift    = (state == S_SCAN) || (state == S_CLAIM);
  assign pos_port = port_base + 16'(pos);

  // Head control for the entry at the tail of the chain.
  always_comb begin
    hctrl.searching  = !found;
    hctrl.claim_here = (pos == free_idx);
    hctrl.ext_port   = pos_port;
    hctrl.tick_now   = tick_now;
    hctrl.timeout    = timeout_ticks;
    if (state == S_CLAIM) begin
      hctrl.mode = HM_CLAIM;
    end else begin
      case (op_t'(req.operation))
        OP_OUT:  hctrl.mode = HM_OUT;
        OP_IN:   hctrl.mode = HM_IN;
        OP_TICK: hctrl.mode = HM_TICK;
        default: hctrl.mode = HM_TICK;
      endcase
    end
  end

  tnat_head u_head (
    .e_in  (chain[ENTRIES-1]),
    .req   (req),
    .ctrl  (hctrl),
    .e_out (head_out),
    .ev    (hev)
  );

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    if (k == 0) begin : g_first
      tnat_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(head_out), .q(chain[k]));
    end else begin : g_rest
      tnat_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(chain[k-1]),
                        .q(chain[k]));
    end
  end

  assign free_now = hev.is_free && !free_found;
  assign free_sel = free_found ? free_idx : pos;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pub_ip        <= 32'd0;
      port_base     <= 16'd0;
      timeout_ticks <= 16'd60;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_EXT_IP:  pub_ip        <= cfg_data;
        REG_BASE:    port_base     <= cfg_data[15:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      tick_now   <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            req        <= in_data;
            pos        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            case (op_t'(in_data.operation))
              OP_OUT: begin
                res   <= '{ST_FULL, in_data.src_ip, in_data.src_port, 9'd0};
                state <= S_SCAN;
              end
              OP_IN: begin
                if (in_data.dst_ip == pub_ip) begin
                  res   <= '{ST_MISS, in_data.dst_ip, in_data.dst_port, 9'd0};
                  state <= S_SCAN;
                end else begin
                  res   <= '{ST_BAD, in_data.dst_ip, in_data.dst_port, 9'd0};
                  state <= S_FIN;
                end
              end
              OP_TICK: begin
                res      <= '{ST_SWEEP, 32'd0, 16'd0, 9'd0};
                tick_now <= tick_now + 32'd1;
                state    <= S_SCAN;
              end
              default: begin
                res   <= '{ST_BAD, 32'd0, 16'd0, 9'd0};
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          pos <= pos + 1'b1;
          if (hev.took) begin
            found <= 1'b1;
            if (op_t'(req.operation) == OP_OUT) begin
              res <= '{ST_HIT, pub_ip, pos_port, 9'd0};
            end else begin
              res <= '{ST_HIT, chain[ENTRIES-1].inside_ip, chain[ENTRIES-1].inside_port,
                       9'd0};
            end
          end
          if (hev.kill && res.removed_count != 9'h1FF) begin
            res.removed_count <= res.removed_count + 9'd1;
          end
          if (free_now) begin
            free_found <= 1'b1;
            free_idx   <= pos;
          end
          if (pos == LAST) begin
            if (op_t'(req.operation) == OP_OUT && !found && !hev.took &&
                (free_found || free_now)) begin
              res      <= '{ST_NEW, pub_ip, port_base + 16'(free_sel), 9'd0};
              free_idx <= free_sel;
              state    <= S_CLAIM;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CLAIM: begin
          pos <= pos + 1'b1;
          if (pos == LAST) state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> pos == '0)
    else $error("chain not aligned at rest");
  a_claim_no_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_CLAIM |-> !found && free_found)
    else $error("claim pass without a free entry or after a hit");
  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !(out_valid && out_stall) |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule
